[rtl/rpmc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpmc_pkg
// Shared types, field widths and codes for the read pair merge classifier.
// ----------------------------------------------------------------------------
package rpmc_pkg;

    // field widths
    localparam int OP_W    = 3;
    localparam int ID_W    = 32;
    localparam int POS_W   = 31;
    localparam int LEN_W   = 16;
    localparam int BIN_W   = 10;
    localparam int KIND_W  = 3;
    localparam int RK_W    = 3;
    localparam int CLS_W   = 2;
    localparam int CNT_W   = 32;
    localparam int BSZ_W   = 16;

    // defaults
    localparam int DEF_LIST_DEPTH    = 1024;
    localparam int DEF_COVERAGE_BINS = 1024;
    localparam logic [BSZ_W-1:0] BIN_SIZE_RESET = 16'd1000;

    // opcodes
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD_A  = 3'd1;
    localparam logic [OP_W-1:0] OP_LOAD_B  = 3'd2;
    localparam logic [OP_W-1:0] OP_MERGE   = 3'd3;
    localparam logic [OP_W-1:0] OP_COUNTER = 3'd4;

    // result kinds
    localparam logic [RK_W-1:0] RK_PAIR    = 3'd0;
    localparam logic [RK_W-1:0] RK_ADVANCE = 3'd1;
    localparam logic [RK_W-1:0] RK_DONE    = 3'd2;
    localparam logic [RK_W-1:0] RK_COUNTER = 3'd3;
    localparam logic [RK_W-1:0] RK_RANGE   = 3'd4;

    // orientation classes
    localparam logic [CLS_W-1:0] CLS_TH = 2'd0;
    localparam logic [CLS_W-1:0] CLS_HT = 2'd1;
    localparam logic [CLS_W-1:0] CLS_TT = 2'd2;
    localparam logic [CLS_W-1:0] CLS_HH = 2'd3;

    // counter kinds
    localparam logic [KIND_W-1:0] CK_TOTAL = 3'd6;
    localparam logic [KIND_W-1:0] CK_NONE  = 3'd7;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [POS_W-1:0] pos;
        logic [LEN_W-1:0] len;
        logic             strand;
        logic             fwd;
    } entry_t;

    typedef struct packed {
        logic [RK_W-1:0]  result_kind;
        logic [CLS_W-1:0] pair_class;
        logic [ID_W-1:0]  pair_id;
        logic [POS_W-1:0] first_position;
        logic [LEN_W-1:0] first_length;
        logic             first_strand;
        logic             first_forward;
        logic [POS_W-1:0] second_position;
        logic [LEN_W-1:0] second_length;
        logic             second_forward;
        logic [CNT_W-1:0] insert_size;
        logic [CNT_W-1:0] count_value;
    } result_t;

endpackage

[rtl/rpmc_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpmc_req_if
// Request channel: valid/ready handshake carrying one command item.
// ----------------------------------------------------------------------------
interface rpmc_req_if;
    logic                          valid;
    logic                          ready;
    logic [rpmc_pkg::OP_W-1:0]     opcode;
    logic [rpmc_pkg::ID_W-1:0]     read_id;
    logic [rpmc_pkg::POS_W-1:0]    position;
    logic [rpmc_pkg::LEN_W-1:0]    read_length;
    logic                          strand;
    logic                          from_forward_file;
    logic [rpmc_pkg::BIN_W-1:0]    counter_bin;
    logic [rpmc_pkg::KIND_W-1:0]   counter_kind;

    modport source (output valid, opcode, read_id, position, read_length, strand,
                    from_forward_file, counter_bin, counter_kind, input ready);
    modport sink (input valid, opcode, read_id, position, read_length, strand,
                  from_forward_file, counter_bin, counter_kind, output ready);
endinterface

[rtl/rpmc_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpmc_rsp_if
// Response channel: valid/ready handshake carrying one result item.
// ----------------------------------------------------------------------------
interface rpmc_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [rpmc_pkg::RK_W-1:0]     result_kind;
    logic [rpmc_pkg::CLS_W-1:0]    pair_class;
    logic [rpmc_pkg::ID_W-1:0]     pair_id;
    logic [rpmc_pkg::POS_W-1:0]    first_position;
    logic [rpmc_pkg::LEN_W-1:0]    first_length;
    logic                          first_strand;
    logic                          first_forward;
    logic [rpmc_pkg::POS_W-1:0]    second_position;
    logic [rpmc_pkg::LEN_W-1:0]    second_length;
    logic                          second_forward;
    logic [rpmc_pkg::CNT_W-1:0]    insert_size;
    logic [rpmc_pkg::CNT_W-1:0]    count_value;

    modport source (output valid, result_kind, pair_class, pair_id, first_position,
                    first_length, first_strand, first_forward, second_position,
                    second_length, second_forward, insert_size, count_value,
                    input ready);
    modport sink (input valid, result_kind, pair_class, pair_id, first_position,
                  first_length, first_strand, first_forward, second_position,
                  second_length, second_forward, insert_size, count_value,
                  output ready);
endinterface

[rtl/rpmc_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpmc_div
// Restoring serial divider: position by bin size, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module rpmc_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [rpmc_pkg::POS_W-1:0]    dividend,
    input  logic [rpmc_pkg::BSZ_W-1:0]    divisor,
    output logic                          done,
    output logic [rpmc_pkg::POS_W-1:0]    quotient
);
    localparam int QW = rpmc_pkg::POS_W;
    localparam int DW = rpmc_pkg::BSZ_W;
    localparam int CW = $clog2(QW);

    logic [QW-1:0] quo_reg, quo_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW:0]   shifted;
    logic          fits;

    // one shift and trial subtract per cycle
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[QW-1]};
        fits      = (shifted >= {1'b0, dvs_reg});
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DW'(shifted - {1'b0, dvs_reg}) : DW'(shifted);
            quo_next = {quo_reg[QW-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(QW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[rtl/read_pair_merge_classifier_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// read_pair_merge_classifier_top
// Merge join of two ID-sorted read lists with pair classing and coverage bins.
// ----------------------------------------------------------------------------
// Usage: commands enter on req (valid/ready), results leave on rsp
// (valid/ready). cfg_we/cfg_wdata set the coverage bin width (reset 1000).
// Loads and opcodes 5..7 give no item. Clear starts a sweep that zeroes the
// counter memory one entry a cycle; the same sweep runs after reset before
// req.ready rises. A counter read of a bin reads the counter memory. A
// merge step gives done when a list is used up and advances a head when
// the IDs differ. When a pair is found, two divisions on the one serial
// divider give the two bins, then an in-range pair not of class TH takes
// two read-modify-write passes on the counter memory.
// One item is in work at a time; req.ready is high only between items.
// The finished item sits in an output register; if rsp stalls the block
// holds the next result until the register is free.
// ----------------------------------------------------------------------------
module read_pair_merge_classifier_top
#(
    parameter int LIST_DEPTH    = rpmc_pkg::DEF_LIST_DEPTH,
    parameter int COVERAGE_BINS = rpmc_pkg::DEF_COVERAGE_BINS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [rpmc_pkg::BSZ_W-1:0]    cfg_wdata,
    rpmc_req_if.sink                      req,
    rpmc_rsp_if.source                    rsp
);
    localparam int LAW   = $clog2(LIST_DEPTH);
    localparam int LCW   = $clog2(LIST_DEPTH + 1);
    localparam int CDEP  = 6 * COVERAGE_BINS;
    localparam int CAW   = (CDEP > 1) ? $clog2(CDEP) : 1;
    localparam int POS_W = rpmc_pkg::POS_W;
    localparam int LEN_W = rpmc_pkg::LEN_W;
    localparam int CNT_W = rpmc_pkg::CNT_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CLR  = 4'd1;
    localparam logic [3:0] S_MRD  = 4'd2;
    localparam logic [3:0] S_MCMP = 4'd3;
    localparam logic [3:0] S_DIV1 = 4'd4;
    localparam logic [3:0] S_DIV2 = 4'd5;
    localparam logic [3:0] S_BRD1 = 4'd6;
    localparam logic [3:0] S_BWR1 = 4'd7;
    localparam logic [3:0] S_BRD2 = 4'd8;
    localparam logic [3:0] S_BWR2 = 4'd9;
    localparam logic [3:0] S_CRD  = 4'd10;
    localparam logic [3:0] S_CWT  = 4'd11;
    localparam logic [3:0] S_OUT  = 4'd12;

    // memories
    rpmc_pkg::entry_t list_a_mem [LIST_DEPTH];
    rpmc_pkg::entry_t list_b_mem [LIST_DEPTH];
    logic [CNT_W-1:0] cov_mem    [CDEP];

    logic [3:0]             state_reg, state_next;
    logic [LCW-1:0]         cnt_a_reg, cnt_a_next, cnt_b_reg, cnt_b_next;
    logic [LCW-1:0]         head_a_reg, head_a_next, head_b_reg, head_b_next;
    logic [CNT_W-1:0]       total_reg, total_next;
    logic [rpmc_pkg::BSZ_W-1:0] bsz_reg;
    logic [CAW-1:0]         clr_reg, clr_next;
    logic [CAW-1:0]         cov_addr_reg, cov_addr_next;
    logic [CAW-1:0]         addr2_reg, addr2_next;
    logic [POS_W-1:0]       bin1_reg, bin1_next;
    rpmc_pkg::result_t      res_reg, res_next;
    rpmc_pkg::result_t      out_reg;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_load;

    rpmc_pkg::entry_t       rd_a_reg, rd_b_reg;
    logic [CNT_W-1:0]       cov_rd_reg;

    logic                   wa_en, wb_en, cov_we;
    logic [LAW-1:0]         wa_addr, wb_addr;
    rpmc_pkg::entry_t       wa_data, wb_data, ld_entry, lo, hi;
    logic [CAW-1:0]         cov_waddr;
    logic [CNT_W-1:0]       cov_wdata;

    logic                   div_start, div_done;
    logic [POS_W-1:0]       div_dividend, div_q;
    logic [rpmc_pkg::BSZ_W-1:0] div_divisor;

    logic                   acc, slot_free;
    logic [1:0]             cls;
    logic [POS_W-1:0]       pos_diff;
    logic [POS_W+1:0]       ins_sum;

    assign acc       = req.valid && req.ready;
    assign slot_free = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE);

    // loaded entry from the request
    always_comb
    begin
        ld_entry.id     = req.read_id;
        ld_entry.pos    = req.position;
        ld_entry.len    = req.read_length;
        ld_entry.strand = req.strand;
        ld_entry.fwd    = req.from_forward_file;
    end

    // pair ordering, class and insert size from the two heads
    always_comb
    begin
        if (rd_a_reg.pos < rd_b_reg.pos)
        begin
            lo = rd_a_reg;
            hi = rd_b_reg;
        end
        else
        begin
            lo = rd_b_reg;
            hi = rd_a_reg;
        end
        if (lo.strand == hi.strand)
            cls = (lo.fwd == lo.strand) ? rpmc_pkg::CLS_TH : rpmc_pkg::CLS_HT;
        else
            cls = (lo.fwd == lo.strand) ? rpmc_pkg::CLS_TT : rpmc_pkg::CLS_HH;
        pos_diff = hi.pos - lo.pos;
        ins_sum  = {2'b00, pos_diff} + {(POS_W + 2 - LEN_W)'(0), hi.len};
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_a_next     = cnt_a_reg;
        cnt_b_next     = cnt_b_reg;
        head_a_next    = head_a_reg;
        head_b_next    = head_b_reg;
        total_next     = total_reg;
        clr_next       = clr_reg;
        cov_addr_next  = cov_addr_reg;
        addr2_next     = addr2_reg;
        bin1_next      = bin1_reg;
        res_next       = res_reg;
        out_load       = 1'b0;
        wa_en          = 1'b0;
        wb_en          = 1'b0;
        wa_addr        = head_a_reg[LAW-1:0];
        wb_addr        = head_b_reg[LAW-1:0];
        wa_data        = ld_entry;
        wb_data        = ld_entry;
        cov_we         = 1'b0;
        cov_waddr      = cov_addr_reg;
        cov_wdata      = cov_rd_reg + 1'b1;
        div_start      = 1'b0;
        div_dividend   = res_reg.first_position;
        div_divisor    = (bsz_reg == '0) ? rpmc_pkg::BSZ_W'(1) : bsz_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    res_next = '0;
                    case (req.opcode)
                        rpmc_pkg::OP_CLEAR:
                        begin
                            cnt_a_next  = '0;
                            cnt_b_next  = '0;
                            head_a_next = '0;
                            head_b_next = '0;
                            total_next  = '0;
                            clr_next    = '0;
                            state_next  = S_CLR;
                        end
                        rpmc_pkg::OP_LOAD_A:
                        begin
                            if (cnt_a_reg < LCW'(LIST_DEPTH))
                            begin
                                wa_en      = 1'b1;
                                wa_addr    = cnt_a_reg[LAW-1:0];
                                cnt_a_next = cnt_a_reg + 1'b1;
                            end
                        end
                        rpmc_pkg::OP_LOAD_B:
                        begin
                            if (cnt_b_reg < LCW'(LIST_DEPTH))
                            begin
                                wb_en      = 1'b1;
                                wb_addr    = cnt_b_reg[LAW-1:0];
                                cnt_b_next = cnt_b_reg + 1'b1;
                            end
                        end
                        rpmc_pkg::OP_MERGE:
                        begin
                            if (head_a_reg >= cnt_a_reg || head_b_reg >= cnt_b_reg)
                            begin
                                res_next.result_kind = rpmc_pkg::RK_DONE;
                                state_next           = S_OUT;
                            end
                            else
                                state_next = S_MRD;
                        end
                        rpmc_pkg::OP_COUNTER:
                        begin
                            res_next.result_kind = rpmc_pkg::RK_COUNTER;
                            if (req.counter_kind == rpmc_pkg::CK_TOTAL)
                            begin
                                res_next.count_value = total_reg;
                                state_next           = S_OUT;
                            end
                            else if (req.counter_kind == rpmc_pkg::CK_NONE)
                                state_next = S_OUT;
                            else if ({22'd0, req.counter_bin} >= 32'(COVERAGE_BINS))
                            begin
                                res_next.result_kind = rpmc_pkg::RK_RANGE;
                                state_next           = S_OUT;
                            end
                            else
                            begin
                                cov_addr_next = CAW'(CAW'(req.counter_kind) *
                                                CAW'(COVERAGE_BINS)
                                                + CAW'(req.counter_bin));
                                state_next    = S_CRD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_CLR:
            begin
                cov_we    = 1'b1;
                cov_waddr = clr_reg;
                cov_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == CAW'(CDEP - 1))
                    state_next = S_IDLE;
            end
            S_MRD:
                state_next = S_MCMP;
            S_MCMP:
            begin
                if (rd_a_reg.id == '0)
                begin
                    head_a_next          = head_a_reg + 1'b1;
                    res_next.result_kind = rpmc_pkg::RK_ADVANCE;
                    state_next           = S_OUT;
                end
                else if (rd_b_reg.id == '0)
                begin
                    head_b_next          = head_b_reg + 1'b1;
                    res_next.result_kind = rpmc_pkg::RK_ADVANCE;
                    state_next           = S_OUT;
                end
                else if (rd_a_reg.id != rd_b_reg.id)
                begin
                    if (rd_a_reg.id > rd_b_reg.id)
                        head_a_next = head_a_reg + 1'b1;
                    else
                        head_b_next = head_b_reg + 1'b1;
                    res_next.result_kind = rpmc_pkg::RK_ADVANCE;
                    state_next           = S_OUT;
                end
                else
                begin
                    res_next.pair_class      = cls;
                    res_next.pair_id         = rd_a_reg.id;
                    res_next.first_position  = lo.pos;
                    res_next.first_length    = lo.len;
                    res_next.first_strand    = lo.strand;
                    res_next.first_forward   = lo.fwd;
                    res_next.second_position = hi.pos;
                    res_next.second_length   = hi.len;
                    res_next.second_forward  = hi.fwd;
                    if (cls == rpmc_pkg::CLS_TH && ins_sum != '0)
                        res_next.insert_size = CNT_W'(ins_sum - 1'b1);
                    // mark both entries taken
                    wa_en       = 1'b1;
                    wb_en       = 1'b1;
                    wa_data     = rd_a_reg;
                    wb_data     = rd_b_reg;
                    wa_data.id  = '0;
                    wb_data.id  = '0;
                    head_a_next = head_a_reg + 1'b1;
                    head_b_next = head_b_reg + 1'b1;
                    div_start    = 1'b1;
                    div_dividend = lo.pos;
                    state_next   = S_DIV1;
                end
            end
            S_DIV1:
            begin
                if (div_done)
                begin
                    bin1_next    = div_q;
                    div_start    = 1'b1;
                    div_dividend = res_reg.second_position;
                    state_next   = S_DIV2;
                end
            end
            S_DIV2:
            begin
                if (div_done)
                begin
                    if (bin1_reg >= POS_W'(COVERAGE_BINS) || div_q >= POS_W'(COVERAGE_BINS))
                    begin
                        res_next.result_kind = rpmc_pkg::RK_RANGE;
                        state_next           = S_OUT;
                    end
                    else if (res_reg.pair_class == rpmc_pkg::CLS_TH)
                    begin
                        total_next           = total_reg + 1'b1;
                        res_next.result_kind = rpmc_pkg::RK_PAIR;
                        state_next           = S_OUT;
                    end
                    else
                    begin
                        // upstream kind = class-1, downstream kind = class+2
                        cov_addr_next = CAW'(CAW'(res_reg.pair_class - 1'b1) *
                                        CAW'(COVERAGE_BINS) + CAW'(bin1_reg));
                        addr2_next    = CAW'(CAW'({1'b0, res_reg.pair_class} + 3'd2) *
                                        CAW'(COVERAGE_BINS) + CAW'(div_q));
                        state_next    = S_BRD1;
                    end
                end
            end
            S_BRD1:
                state_next = S_BWR1;
            S_BWR1:
            begin
                cov_we        = 1'b1;
                cov_addr_next = addr2_reg;
                state_next    = S_BRD2;
            end
            S_BRD2:
                state_next = S_BWR2;
            S_BWR2:
            begin
                cov_we               = 1'b1;
                total_next           = total_reg + 1'b1;
                res_next.result_kind = rpmc_pkg::RK_PAIR;
                state_next           = S_OUT;
            end
            S_CRD:
                state_next = S_CWT;
            S_CWT:
            begin
                res_next.count_value = cov_rd_reg;
                state_next           = S_OUT;
            end
            S_OUT:
            begin
                if (slot_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase

        out_valid_next = out_valid_reg && !rsp.ready;
        if (out_load)
            out_valid_next = 1'b1;
    end

    // control registers; the counter sweep runs after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            cnt_a_reg     <= '0;
            cnt_b_reg     <= '0;
            head_a_reg    <= '0;
            head_b_reg    <= '0;
            total_reg     <= '0;
            clr_reg       <= '0;
            bsz_reg       <= rpmc_pkg::BIN_SIZE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_a_reg     <= cnt_a_next;
            cnt_b_reg     <= cnt_b_next;
            head_a_reg    <= head_a_next;
            head_b_reg    <= head_b_next;
            total_reg     <= total_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                bsz_reg <= cfg_wdata;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cov_addr_reg <= cov_addr_next;
        addr2_reg    <= addr2_next;
        bin1_reg     <= bin1_next;
        res_reg      <= res_next;
        if (out_load)
            out_reg <= res_reg;
    end

    // list memories
    always_ff @(posedge clk)
    begin
        if (wa_en)
            list_a_mem[wa_addr] <= wa_data;
        rd_a_reg <= list_a_mem[head_a_reg[LAW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (wb_en)
            list_b_mem[wb_addr] <= wb_data;
        rd_b_reg <= list_b_mem[head_b_reg[LAW-1:0]];
    end

    // coverage counter memory
    always_ff @(posedge clk)
    begin
        if (cov_we)
            cov_mem[cov_waddr] <= cov_wdata;
        cov_rd_reg <= cov_mem[cov_addr_reg];
    end

    rpmc_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // response port
    assign rsp.valid           = out_valid_reg;
    assign rsp.result_kind     = out_reg.result_kind;
    assign rsp.pair_class      = out_reg.pair_class;
    assign rsp.pair_id         = out_reg.pair_id;
    assign rsp.first_position  = out_reg.first_position;
    assign rsp.first_length    = out_reg.first_length;
    assign rsp.first_strand    = out_reg.first_strand;
    assign rsp.first_forward   = out_reg.first_forward;
    assign rsp.second_position = out_reg.second_position;
    assign rsp.second_length   = out_reg.second_length;
    assign rsp.second_forward  = out_reg.second_forward;
    assign rsp.insert_size     = out_reg.insert_size;
    assign rsp.count_value     = out_reg.count_value;

endmodule
